// ----- rtl/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg - shared definitions for the layer priority compositor
// Layer codes, effect modes, register indexes and the effect command struct.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int NUM_BG   = 4;
	localparam int PIX_W    = 16;
	localparam int COLOR_W  = 15;
	localparam int CH_W     = 5;
	localparam int LAYER_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [LAYER_W-1:0] LAYER_SPRITE   = 3'd4;
	localparam logic [LAYER_W-1:0] LAYER_BACKDROP = 3'd5;

	localparam logic [1:0] MODE_NONE     = 2'd0;
	localparam logic [1:0] MODE_BLEND    = 2'd1;
	localparam logic [1:0] MODE_BRIGHTEN = 2'd2;
	localparam logic [1:0] MODE_DARKEN   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG_PRIORITIES    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INSIDE_WINDOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE_WINDOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_CONTROL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHTS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BACKDROP_COLOR   = 3'd7;

	localparam logic [CH_W-1:0] CH_MAX     = 5'd31;
	localparam logic [CH_W-1:0] WEIGHT_CAP = 5'd16;

	typedef struct packed {
		logic            alpha;
		logic            bright;
		logic            darken;
		logic [CH_W-1:0] eva;
		logic [CH_W-1:0] evb;
		logic [CH_W-1:0] evy;
	} fx_cmd_t;

	function automatic logic [CH_W-1:0] cap_weight(input logic [CH_W-1:0] w);
		cap_weight = (w > WEIGHT_CAP) ? WEIGHT_CAP : w;
	endfunction

endpackage

// ----- rtl/layer_priority_compositor_with_blend.sv -----
// ----------------------------------------------------------------------------
// layer_priority_compositor_with_blend - 2D pixel compositor with colour effects
// Window selection, priority sort of four backgrounds and one object, blending.
// ----------------------------------------------------------------------------
// Takes one pixel per clock as long as the output is taken: the pixel is
// captured in an input register, then windowing, the priority sort and the
// colour effect are resolved in a single pass into the output register, which
// drives the outputs. While a result waits, one more pixel is captured and
// then the input stalls until the result is taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module layer_priority_compositor_with_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lpc_pkg::PIX_W-1:0]         bg0_color,
	input  logic [lpc_pkg::PIX_W-1:0]         bg1_color,
	input  logic [lpc_pkg::PIX_W-1:0]         bg2_color,
	input  logic [lpc_pkg::PIX_W-1:0]         bg3_color,
	input  logic [lpc_pkg::PIX_W-1:0]         sprite_color,
	input  logic [1:0]                        sprite_priority,
	input  logic                              sprite_semitransparent,
	input  logic                              sprite_window_hit,
	input  logic                              win0_inside,
	input  logic                              win1_inside,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lpc_pkg::COLOR_W-1:0]       out_color,
	output logic [lpc_pkg::LAYER_W-1:0]       top_layer
);
	import lpc_pkg::*;

	logic [7:0]         disp_q;
	logic [7:0]         bgprio_q;
	logic [11:0]        winin_q;
	logic [11:0]        winout_q;
	logic [13:0]        fx_q;
	logic [9:0]         bldw_q;
	logic [4:0]         bldy_q;
	logic [COLOR_W-1:0] backdrop_q;

	logic               v_s1;
	logic [PIX_W-1:0]   bg_s1 [NUM_BG];
	logic [PIX_W-1:0]   obj_s1;
	logic [1:0]         objprio_s1;
	logic               semi_s1;
	logic               objwin_s1;
	logic               win0_s1;
	logic               win1_s1;

	logic               v_s2;
	logic               s2_free;
	logic               s1_free;
	logic               s1_load;

	logic [5:0]         en;
	logic [NUM_BG-1:0]  bg_open;
	logic [1:0]         rank [NUM_BG];
	logic [LAYER_W-1:0] bg_l0;
	logic [LAYER_W-1:0] bg_l1;
	logic [2:0]         prio0;
	logic [2:0]         prio1;
	logic               obj_ok;
	logic [LAYER_W-1:0] layer0;
	logic [LAYER_W-1:0] layer1;
	logic               alpha_obj;
	logic [COLOR_W-1:0] px0;
	logic [COLOR_W-1:0] px1;
	logic [1:0]         mode;
	logic [5:0]         src_mask;
	logic               top_first;
	logic               under_second;
	logic               sfx_en;
	logic               force_blend;
	fx_cmd_t            cmd;
	logic [COLOR_W-1:0] fx_color;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q     <= '0;
			bgprio_q   <= '0;
			winin_q    <= '0;
			winout_q   <= '0;
			fx_q       <= '0;
			bldw_q     <= '0;
			bldy_q     <= '0;
			backdrop_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DISPLAY_ENABLES: disp_q     <= cfg_data[7:0];
				REG_BG_PRIORITIES:   bgprio_q   <= cfg_data[7:0];
				REG_INSIDE_WINDOW:   winin_q    <= cfg_data[11:0];
				REG_OUTSIDE_WINDOW:  winout_q   <= cfg_data[11:0];
				REG_EFFECT_CONTROL:  fx_q       <= cfg_data[13:0];
				REG_BLEND_WEIGHTS:   bldw_q     <= cfg_data[9:0];
				REG_BRIGHTNESS:      bldy_q     <= cfg_data[4:0];
				REG_BACKDROP_COLOR:  backdrop_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign s2_free  = !v_s2 || !out_stall;
	assign s1_free  = !v_s1 || s2_free;
	assign in_stall = !s1_free;
	assign s1_load  = in_valid && s1_free;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= in_valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s1_load) begin
			bg_s1[0]   <= bg0_color;
			bg_s1[1]   <= bg1_color;
			bg_s1[2]   <= bg2_color;
			bg_s1[3]   <= bg3_color;
			obj_s1     <= sprite_color;
			objprio_s1 <= sprite_priority;
			semi_s1    <= sprite_semitransparent;
			objwin_s1  <= sprite_window_hit;
			win0_s1    <= win0_inside;
			win1_s1    <= win1_inside;
		end
	end

	// window selection
	always_comb begin
		if (disp_q[7:5] == 3'b000) begin
			en = 6'h3F;
		end else if (disp_q[5] && win0_s1) begin
			en = winin_q[5:0];
		end else if (disp_q[6] && win1_s1) begin
			en = winin_q[11:6];
		end else if (disp_q[7] && objwin_s1) begin
			en = winout_q[11:6];
		end else begin
			en = winout_q[5:0];
		end
	end

	// background sort by {priority, number}
	always_comb begin
		logic [3:0] key_i;
		logic [3:0] key_j;
		bg_l0 = LAYER_BACKDROP;
		bg_l1 = LAYER_BACKDROP;
		prio0 = 3'd4;
		prio1 = 3'd4;
		for (int i = 0; i < NUM_BG; i++) begin
			bg_open[i] = disp_q[i] && en[i] && !bg_s1[i][PIX_W-1];
		end
		for (int i = 0; i < NUM_BG; i++) begin
			rank[i] = 2'd0;
			key_i   = {bgprio_q[2*i +: 2], 2'(i)};
			for (int j = 0; j < NUM_BG; j++) begin
				key_j   = {bgprio_q[2*j +: 2], 2'(j)};
				rank[i] = rank[i] + 2'(bg_open[j] && (key_j < key_i));
			end
		end
		for (int i = 0; i < NUM_BG; i++) begin
			if (bg_open[i] && rank[i] == 2'd0) begin
				bg_l0 = LAYER_W'(i);
				prio0 = {1'b0, bgprio_q[2*i +: 2]};
			end
			if (bg_open[i] && rank[i] == 2'd1) begin
				bg_l1 = LAYER_W'(i);
				prio1 = {1'b0, bgprio_q[2*i +: 2]};
			end
		end
	end

	// object insertion; the object wins ties
	always_comb begin
		obj_ok    = en[4] && disp_q[4] && !obj_s1[PIX_W-1];
		layer0    = bg_l0;
		layer1    = bg_l1;
		alpha_obj = 1'b0;
		if (obj_ok && ({1'b0, objprio_s1} <= prio0)) begin
			layer0    = LAYER_SPRITE;
			layer1    = bg_l0;
			alpha_obj = semi_s1;
		end else if (obj_ok && ({1'b0, objprio_s1} <= prio1)) begin
			layer1 = LAYER_SPRITE;
		end
	end

	function automatic logic [COLOR_W-1:0] layer_color(
		input logic [LAYER_W-1:0] l,
		input logic [PIX_W-1:0]   b0,
		input logic [PIX_W-1:0]   b1,
		input logic [PIX_W-1:0]   b2,
		input logic [PIX_W-1:0]   b3,
		input logic [PIX_W-1:0]   ob,
		input logic [COLOR_W-1:0] bd
	);
		case (l)
			3'd0:         layer_color = b0[COLOR_W-1:0];
			3'd1:         layer_color = b1[COLOR_W-1:0];
			3'd2:         layer_color = b2[COLOR_W-1:0];
			3'd3:         layer_color = b3[COLOR_W-1:0];
			LAYER_SPRITE: layer_color = ob[COLOR_W-1:0];
			default:      layer_color = bd;
		endcase
	endfunction

	assign px0 = layer_color(layer0, bg_s1[0], bg_s1[1], bg_s1[2], bg_s1[3], obj_s1,
		backdrop_q);
	assign px1 = layer_color(layer1, bg_s1[0], bg_s1[1], bg_s1[2], bg_s1[3], obj_s1,
		backdrop_q);

	// effect decision
	assign mode         = fx_q[7:6];
	assign src_mask     = fx_q[13:8];
	assign top_first    = fx_q[layer0];
	assign under_second = src_mask[layer1];
	assign sfx_en       = en[5];
	assign force_blend  = alpha_obj && under_second;

	always_comb begin
		cmd.eva    = cap_weight(bldw_q[4:0]);
		cmd.evb    = cap_weight(bldw_q[9:5]);
		cmd.evy    = cap_weight(bldy_q);
		cmd.darken = (mode == MODE_DARKEN);
		cmd.alpha  = force_blend ||
			((mode == MODE_BLEND) && top_first && under_second && sfx_en);
		cmd.bright = !force_blend &&
			((mode == MODE_BRIGHTEN) || (mode == MODE_DARKEN)) && top_first && sfx_en;
	end

	lpc_effect u_effect (
		.cmd       (cmd),
		.top_col   (px0),
		.under_col (px1),
		.color     (fx_color)
	);

	// result register
	always_ff @(posedge clk) begin
		if (s2_free) begin
			out_color <= fx_color;
			top_layer <= layer0;
		end
	end

`ifndef SYNTHESIS
	a_layer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (top_layer <= LAYER_BACKDROP))
		else $error("top layer out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && out_valid && out_stall))
		else $error("input stalled with downstream free");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s1))
		else $error("result without a captured item");

	a_backdrop_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && top_layer == LAYER_BACKDROP && fx_q[7:6] == MODE_NONE)
			|-> (out_color == backdrop_q))
		else $error("backdrop colour altered with effects off");
`endif

endmodule

// ----- rtl/lpc_effect.sv -----
// ----------------------------------------------------------------------------
// lpc_effect - colour effect unit
// Alpha blend, brighten or darken of the top colour, per 5-bit channel.
// ----------------------------------------------------------------------------
module lpc_effect (
	input  lpc_pkg::fx_cmd_t                cmd,
	input  logic [lpc_pkg::COLOR_W-1:0]     top_col,
	input  logic [lpc_pkg::COLOR_W-1:0]     under_col,
	output logic [lpc_pkg::COLOR_W-1:0]     color
);
	import lpc_pkg::*;

	always_comb begin
		logic [CH_W-1:0] t;
		logic [CH_W-1:0] u;
		logic [9:0]      mix;
		logic [9:0]      dprod;
		logic [9:0]      bprod;
		logic [CH_W-1:0] a_ch;
		logic [CH_W-1:0] d_ch;
		logic [CH_W-1:0] b_ch;
		color = top_col;
		for (int ch = 0; ch < 3; ch++) begin
			t     = top_col[ch*CH_W +: CH_W];
			u     = under_col[ch*CH_W +: CH_W];
			mix   = 10'(t) * 10'(cmd.eva) + 10'(u) * 10'(cmd.evb);
			a_ch  = (mix[9:4] > 6'(CH_MAX)) ? CH_MAX : mix[8:4];
			dprod = 10'(t) * 10'(cmd.evy);
			d_ch  = t - dprod[8:4];
			bprod = 10'(CH_MAX - t) * 10'(cmd.evy);
			b_ch  = t + bprod[8:4];
			if (cmd.alpha) begin
				color[ch*CH_W +: CH_W] = a_ch;
			end else if (cmd.bright) begin
				color[ch*CH_W +: CH_W] = cmd.darken ? d_ch : b_ch;
			end
		end
	end

endmodule

// ----- verif/tb_layer_priority_compositor_with_blend.sv -----
// ----------------------------------------------------------------------------
// tb_layer_priority_compositor_with_blend - self-checking bench for the compositor
// Drives pixels through the valid/stall handshake under several register
// settings, predicts window selection, layer sorting and colour effects, and
// checks every result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_layer_priority_compositor_with_blend;

	import lpc_pkg::*;

	typedef struct packed {
		logic [NUM_BG-1:0][PIX_W-1:0] bg;
		logic [PIX_W-1:0]             obj;
		logic [1:0]                   obj_prio;
		logic                         semi;
		logic                         obj_win;
		logic                         win0;
		logic                         win1;
	} pixel_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [LAYER_W-1:0] layer;
	} result_t;

	typedef struct packed {
		pixel_t  pix;
		logic    fixed;
		result_t want;
	} send_t;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
		send_t                 item;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [COLOR_W-1:0] out_color;
	logic [LAYER_W-1:0] top_layer;

	pixel_t  drive_pix = '0;
	logic    cur_fixed = 1'b0;
	result_t cur_want = '0;
	logic    in_fired = 1'b0;
	logic    no_idle = 1'b0;
	logic    hold_request = 1'b0;
	int      fault_count = 0;

	logic [7:0]         disp_en = '0;
	logic [7:0]         bg_prio = '0;
	logic [11:0]        win_in = '0;
	logic [11:0]        win_out = '0;
	logic [13:0]        fx_ctrl = '0;
	logic [9:0]         blend_w = '0;
	logic [4:0]         bright_w = '0;
	logic [COLOR_W-1:0] backdrop = '0;

	send_t       pending_pixels[$];
	result_t     predicted_pixels[$];
	script_row_t directed_rows[$];

	layer_priority_compositor_with_blend DUT (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.bg0_color              (drive_pix.bg[0]),
		.bg1_color              (drive_pix.bg[1]),
		.bg2_color              (drive_pix.bg[2]),
		.bg3_color              (drive_pix.bg[3]),
		.sprite_color           (drive_pix.obj),
		.sprite_priority        (drive_pix.obj_prio),
		.sprite_semitransparent (drive_pix.semi),
		.sprite_window_hit      (drive_pix.obj_win),
		.win0_inside            (drive_pix.win0),
		.win1_inside            (drive_pix.win1),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.out_color              (out_color),
		.top_layer              (top_layer)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int clamp_weight(input logic [4:0] w);
		return (w > WEIGHT_CAP) ? int'(WEIGHT_CAP) : int'(w);
	endfunction

	function automatic logic [COLOR_W-1:0] blend_colours(input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b);
		logic [COLOR_W-1:0] mix;
		int eva, evb, c, ch;
		eva = clamp_weight(blend_w[4:0]);
		evb = clamp_weight(blend_w[9:5]);
		for (ch = 0; ch < 3; ch++) begin
			c = (int'(a[5*ch +: 5]) * eva + int'(b[5*ch +: 5]) * evb) >> 4;
			if (c > int'(CH_MAX))
				c = int'(CH_MAX);
			mix[5*ch +: 5] = c[4:0];
		end
		return mix;
	endfunction

	function automatic logic [COLOR_W-1:0] shade_colour(input logic [COLOR_W-1:0] a,
			input logic darken);
		logic [COLOR_W-1:0] mix;
		int evy, c, ch;
		evy = clamp_weight(bright_w);
		for (ch = 0; ch < 3; ch++) begin
			c = int'(a[5*ch +: 5]);
			if (darken)
				c = c - ((c * evy) >> 4);
			else
				c = c + (((int'(CH_MAX) - c) * evy) >> 4);
			mix[5*ch +: 5] = c[4:0];
		end
		return mix;
	endfunction

	function automatic logic [COLOR_W-1:0] layer_colour(input pixel_t p,
			input logic [LAYER_W-1:0] layer);
		if (layer < LAYER_SPRITE)
			return p.bg[layer[1:0]][COLOR_W-1:0];
		else if (layer == LAYER_SPRITE)
			return p.obj[COLOR_W-1:0];
		else
			return backdrop;
	endfunction

	function automatic result_t compose_pixel(input pixel_t p);
		logic [5:0]         en;
		logic [LAYER_W-1:0] top, under;
		logic [2:0]         top_prio, under_prio;
		logic [1:0]         bprio;
		logic [COLOR_W-1:0] top_px, under_px, mixed;
		logic               semi_top, dst, src;
		int                 pr, b;
		result_t            r;

		if (disp_en[7:5] == 3'b000)
			en = 6'h3F;
		else if (disp_en[5] && p.win0)
			en = win_in[5:0];
		else if (disp_en[6] && p.win1)
			en = win_in[11:6];
		else if (disp_en[7] && p.obj_win)
			en = win_out[11:6];
		else
			en = win_out[5:0];

		top = LAYER_BACKDROP;
		under = LAYER_BACKDROP;
		top_prio = 3'd4;
		under_prio = 3'd4;
		semi_top = 1'b0;
		for (pr = 3; pr >= 0; pr--) begin
			for (b = 3; b >= 0; b--) begin
				bprio = bg_prio[2*b +: 2];
				if (disp_en[b] && int'(bprio) == pr && en[b] && !p.bg[b][15]) begin
					under = top;
					top = LAYER_W'(b);
					under_prio = top_prio;
					top_prio = {1'b0, bprio};
				end
			end
		end

		if (en[4] && disp_en[4] && !p.obj[15]) begin
			if ({1'b0, p.obj_prio} <= top_prio) begin
				under = top;
				top = LAYER_SPRITE;
				semi_top = p.semi;
			end else if ({1'b0, p.obj_prio} <= under_prio) begin
				under = LAYER_SPRITE;
			end
		end

		top_px = layer_colour(p, top);
		under_px = layer_colour(p, under);
		dst = fx_ctrl[top];
		src = fx_ctrl[8 + under];
		mixed = top_px;
		if (semi_top && src)
			mixed = blend_colours(top_px, under_px);
		else if (fx_ctrl[7:6] == MODE_BLEND) begin
			if (dst && src && en[5])
				mixed = blend_colours(top_px, under_px);
		end else if (fx_ctrl[7:6] != MODE_NONE) begin
			if (dst && en[5])
				mixed = shade_colour(top_px, fx_ctrl[7:6] == MODE_DARKEN);
		end
		r.color = mixed;
		r.layer = top;
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] random_colour();
		case ($urandom_range(0, 9))
			0, 1, 2: return {1'b1, 15'($urandom)};
			3: return 16'h0000;
			4: return 16'h7FFF;
			default: return {1'b0, 15'($urandom)};
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int b;
		for (b = 0; b < NUM_BG; b++)
			p.bg[b] = random_colour();
		p.obj = random_colour();
		p.obj_prio = 2'($urandom);
		p.semi = 1'($urandom);
		p.obj_win = 1'($urandom);
		p.win0 = 1'($urandom);
		p.win1 = 1'($urandom);
		return p;
	endfunction

	function automatic pixel_t make_pixel(input logic [PIX_W-1:0] b0, b1, b2, b3, obj,
			input logic [1:0] prio, input logic semi, obj_win, win0, win1);
		pixel_t p;
		p.bg[0] = b0;
		p.bg[1] = b1;
		p.bg[2] = b2;
		p.bg[3] = b3;
		p.obj = obj;
		p.obj_prio = prio;
		p.semi = semi;
		p.obj_win = obj_win;
		p.win0 = win0;
		p.win1 = win1;
		return p;
	endfunction

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		script_row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.value = value;
		r.item = '0;
		directed_rows.push_back(r);
	endtask

	task automatic add_pixel(input pixel_t pix, input logic fixed, input result_t want);
		script_row_t r;
		r.kind = ROW_PIXEL;
		r.idx = '0;
		r.value = '0;
		r.item.pix = pix;
		r.item.fixed = fixed;
		r.item.want = want;
		directed_rows.push_back(r);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_DISPLAY_ENABLES: disp_en = value[7:0];
			REG_BG_PRIORITIES:   bg_prio = value[7:0];
			REG_INSIDE_WINDOW:   win_in = value[11:0];
			REG_OUTSIDE_WINDOW:  win_out = value[11:0];
			REG_EFFECT_CONTROL:  fx_ctrl = value[13:0];
			REG_BLEND_WEIGHTS:   blend_w = value[9:0];
			REG_BRIGHTNESS:      bright_w = value[4:0];
			REG_BACKDROP_COLOR:  backdrop = value[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (pending_pixels.size() != 0 || in_valid || predicted_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_item(input send_t item);
		while (pending_pixels.size() >= 8)
			@(posedge clk);
		pending_pixels.push_back(item);
	endtask

	task automatic feed_random(input int count, input int pressure_at);
		send_t item;
		int n;
		for (n = 0; n < count; n++) begin
			if (n == pressure_at)
				hold_request = 1'b1;
			item.pix = random_pixel();
			item.fixed = 1'b0;
			item.want = '0;
			queue_item(item);
		end
	endtask

	task automatic report_fault(input string what, input logic [COLOR_W-1:0] want,
			input logic [COLOR_W-1:0] got);
		fault_count++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
	endtask

	// drive items: hold until taken, idle at random otherwise
	always @(negedge clk) begin : feed
		send_t nxt;
		if (!in_valid || in_fired) begin
			if (pending_pixels.size() != 0 && (no_idle || $urandom_range(0, 99) >= 16)) begin
				nxt = pending_pixels.pop_front();
				drive_pix <= nxt.pix;
				cur_fixed <= nxt.fixed;
				cur_want <= nxt.want;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	initial begin : sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_idle && ($urandom_range(0, 99) < 16);
			end
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (out_valid && !out_stall) begin
			if (predicted_pixels.size() == 0) begin
				report_fault("unexpected item, colour", '0, out_color);
			end else begin
				want = predicted_pixels.pop_front();
				if (out_color !== want.color)
					report_fault("colour", want.color, out_color);
				if (top_layer !== want.layer)
					report_fault("top layer", COLOR_W'(want.layer), COLOR_W'(top_layer));
			end
		end
		in_fired = in_valid && !in_stall;
		if (in_fired)
			predicted_pixels.push_back(cur_fixed ? cur_want : compose_pixel(drive_pix));
	end

	initial begin : watchdog
		#2400000;
		$display("tb_layer_priority_compositor_with_blend: errors");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] v_disp, v_prio, v_win_in, v_win_out, v_fx, v_blend, v_bright, v_bd;
		int phase;

		// reset settings: nothing enabled, black backdrop
		add_pixel(make_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h0000, LAYER_BACKDROP});
		add_pixel(make_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 2'd3,
			1'b1, 1'b1, 1'b1, 1'b1), 1'b1, '{15'h0000, LAYER_BACKDROP});

		// priority sort, no windows, no effect
		add_write(REG_DISPLAY_ENABLES, 15'h001F);
		add_write(REG_BG_PRIORITIES, 15'h00E4);
		add_write(REG_BACKDROP_COLOR, 15'h7FFF);
		add_pixel(make_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h7FFF, LAYER_BACKDROP});
		add_pixel(make_pixel(16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h0000, 3'd0});
		add_pixel(make_pixel(16'hFFFF, 16'h1234, 16'h7FFF, 16'h7FFF, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h1234, 3'd1});
		add_pixel(make_pixel(16'h03E0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7C00, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h7C00, LAYER_SPRITE});
		add_pixel(make_pixel(16'h8000, 16'h8000, 16'h8000, 16'h001F, 16'h0001, 2'd3,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h0001, LAYER_SPRITE});
		add_pixel(make_pixel(16'h8000, 16'h0155, 16'h7FFF, 16'h7FFF, 16'h7C00, 2'd2,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h0155, 3'd1});
		add_write(REG_BG_PRIORITIES, 15'h0000);
		add_pixel(make_pixel(16'h0AAA, 16'h1555, 16'h2AAA, 16'h3555, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h0AAA, 3'd0});

		// window precedence: win0, win1, object window, outside
		add_write(REG_DISPLAY_ENABLES, 15'h00FF);
		add_write(REG_INSIDE_WINDOW, 15'h0102);
		add_write(REG_OUTSIDE_WINDOW, 15'h0408);
		add_pixel(make_pixel(16'h0AAA, 16'h1555, 16'h2AAA, 16'h3555, 16'h7C00, 2'd0,
			1'b0, 1'b1, 1'b1, 1'b1), 1'b1, '{15'h1555, 3'd1});
		add_pixel(make_pixel(16'h0AAA, 16'h1555, 16'h2AAA, 16'h3555, 16'h7C00, 2'd0,
			1'b0, 1'b1, 1'b0, 1'b1), 1'b1, '{15'h2AAA, 3'd2});
		add_pixel(make_pixel(16'h0AAA, 16'h1555, 16'h2AAA, 16'h3555, 16'h7C00, 2'd0,
			1'b0, 1'b1, 1'b0, 1'b0), 1'b1, '{15'h7C00, LAYER_SPRITE});
		add_pixel(make_pixel(16'h0AAA, 16'h1555, 16'h2AAA, 16'h3555, 16'h7C00, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b1, '{15'h3555, 3'd3});

		// colour effects
		add_write(REG_DISPLAY_ENABLES, 15'h001F);
		add_write(REG_BG_PRIORITIES, 15'h00E4);
		add_write(REG_EFFECT_CONTROL, {1'b0, 6'h3F, MODE_BLEND, 6'h3F});
		add_write(REG_BLEND_WEIGHTS, 15'h0210);
		add_write(REG_BRIGHTNESS, 15'h001F);
		add_pixel(make_pixel(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		add_pixel(make_pixel(16'h1234, 16'h4321, 16'h8000, 16'h8000, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		add_pixel(make_pixel(16'h0C63, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		add_write(REG_EFFECT_CONTROL, {1'b0, 6'h3F, MODE_BRIGHTEN, 6'h3F});
		add_pixel(make_pixel(16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		add_write(REG_EFFECT_CONTROL, {1'b0, 6'h3F, MODE_DARKEN, 6'h3F});
		add_pixel(make_pixel(16'h7FFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);

		// semi-transparent object forces a blend onto a second target
		add_write(REG_EFFECT_CONTROL, {1'b0, 6'h02, MODE_NONE, 6'h00});
		add_write(REG_BLEND_WEIGHTS, 15'h0127);
		add_pixel(make_pixel(16'h8000, 16'h4210, 16'h7FFF, 16'h7FFF, 16'h7C1F, 2'd0,
			1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		add_pixel(make_pixel(16'h8000, 16'h4210, 16'h7FFF, 16'h7FFF, 16'h7C1F, 2'd0,
			1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		add_pixel(make_pixel(16'h8000, 16'h4210, 16'h7FFF, 16'h7FFF, 16'h7C1F, 2'd3,
			1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				program_reg(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				queue_item(directed_rows[i].item);
			end
		end

		for (phase = 0; phase < 8; phase++) begin
			settle();
			case (phase)
				0: begin
					v_disp = '0; v_prio = '0; v_win_in = '0; v_win_out = '0;
					v_fx = '0; v_blend = '0; v_bright = '0; v_bd = '0;
				end
				1: begin
					v_disp = 15'h00FF; v_prio = 15'h00FF; v_win_in = 15'h0FFF;
					v_win_out = 15'h0FFF; v_fx = 15'h3FFF; v_blend = 15'h03FF;
					v_bright = 15'h001F; v_bd = 15'h7FFF;
				end
				default: begin
					v_disp = 15'($urandom_range(0, 255));
					if ($urandom_range(0, 1))
						v_disp[4:0] = 5'h1F;
					v_prio = 15'($urandom_range(0, 255));
					v_win_in = 15'($urandom_range(0, 4095));
					v_win_out = 15'($urandom_range(0, 4095));
					v_fx = 15'($urandom_range(0, 16383));
					v_blend = 15'($urandom_range(0, 1023));
					v_bright = 15'($urandom_range(0, 31));
					v_bd = 15'($urandom_range(0, 32767));
				end
			endcase
			program_reg(REG_DISPLAY_ENABLES, v_disp);
			program_reg(REG_BG_PRIORITIES, v_prio);
			program_reg(REG_INSIDE_WINDOW, v_win_in);
			program_reg(REG_OUTSIDE_WINDOW, v_win_out);
			program_reg(REG_EFFECT_CONTROL, v_fx);
			program_reg(REG_BLEND_WEIGHTS, v_blend);
			program_reg(REG_BRIGHTNESS, v_bright);
			program_reg(REG_BACKDROP_COLOR, v_bd);
			no_idle = (phase == 5);
			feed_random(210, (phase == 3) ? 60 : -1);
		end

		settle();
		no_idle = 1'b0;
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("tb_layer_priority_compositor_with_blend: clean");
		else
			$display("tb_layer_priority_compositor_with_blend: errors");
		$finish;
	end

endmodule
